[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Depends on nothing; the including scope must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define AST_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked on every rising edge, reset included.
`define AST_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[hw/rtl/mbps_pkg.sv]
// Shared types and constants of the masked byte pattern scan unit.
// Depends on nothing; every module of the block imports it.
package mbps_pkg;

  localparam int MaxPattern = 16;
  localparam int ByteW      = 8;
  localparam int IdxW       = 4;
  localparam int CntW       = 5;
  localparam int AddrW      = 47;
  localparam int CfgDataW   = 64;
  localparam int CfgIdxW    = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegPatLow   = 2'd0,
    RegPatHigh  = 2'd1,
    RegCareMask = 2'd2,
    RegPatLen   = 2'd3
  } cfg_reg_t;

  typedef logic [MaxPattern-1:0][ByteW-1:0] win_t;

  // Pattern, care bits and the clamped pattern length as the matcher uses them.
  typedef struct packed {
    win_t                  pattern;
    logic [MaxPattern-1:0] care;
    logic [CntW-1:0]       length;
  } cfg_t;

  // Window state after the latest accepted word, and whether it awaits a compare.
  typedef struct packed {
    logic             pending;
    win_t             window;
    logic [CntW-1:0]  fill;
    logic [AddrW-1:0] addr;
  } stage_t;

endpackage

[hw/rtl/mbps_cfg.sv]
// Configuration registers of the scan unit and the clamped pattern length.
// Depends on mbps_pkg.
module mbps_cfg
  import mbps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  logic [CfgDataW-1:0]   pat_low;
  logic [CfgDataW-1:0]   pat_high;
  logic [MaxPattern-1:0] care_mask;
  logic [CntW-1:0]       pat_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low   <= '0;
      pat_high  <= '0;
      care_mask <= '1;
      pat_len   <= CntW'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        RegPatLow:   pat_low   <= cfg_data;
        RegPatHigh:  pat_high  <= cfg_data;
        RegCareMask: care_mask <= cfg_data[MaxPattern-1:0];
        RegPatLen:   pat_len   <= cfg_data[CntW-1:0];
        default:     pat_low   <= pat_low;
      endcase
    end
  end

  always_comb begin
    cfg.pattern = {pat_high, pat_low};
    cfg.care    = care_mask;
    // A length of zero behaves as one, anything beyond the window as the full window.
    if (pat_len == '0) begin
      cfg.length = CntW'(1);
    end else if (pat_len > CntW'(MaxPattern)) begin
      cfg.length = CntW'(MaxPattern);
    end else begin
      cfg.length = pat_len;
    end
  end

endmodule

[hw/rtl/mbps_window.sv]
// Shift window of recent bytes, region fill count and the address of the newest byte.
// Depends on mbps_pkg.
module mbps_window
  import mbps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             advance,
  input  logic [ByteW-1:0] data_byte,
  input  logic [AddrW-1:0] byte_address,
  input  logic             region_first,
  output stage_t           stage
);

  // Entry 0 holds the newest byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.pending <= 1'b0;
      stage.fill    <= '0;
    end else begin
      if (advance) begin
        stage.pending <= accept;
      end
      if (accept) begin
        if (region_first) begin
          stage.fill <= CntW'(1);
        end else if (stage.fill < CntW'(MaxPattern)) begin
          stage.fill <= stage.fill + CntW'(1);
        end
      end
    end
    if (accept) begin
      stage.window <= {stage.window[MaxPattern-2:0], data_byte};
      stage.addr   <= byte_address;
    end
  end

endmodule

[hw/rtl/mbps_match.sv]
// Masked compare of the window against the pattern, and the result register.
// Depends on mbps_pkg.
module mbps_match
  import mbps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  stage_t           stage,
  input  cfg_t             cfg,
  input  logic             out_ready,
  output logic             advance,
  output logic             out_valid,
  output logic [AddrW-1:0] match_address
);

  logic [IdxW-1:0] len_m1;
  logic            hit;

  assign advance = !out_valid || out_ready;

  // Pattern byte i lines up with window entry length-1-i.
  always_comb begin
    len_m1 = IdxW'(cfg.length - CntW'(1));
    hit    = stage.fill >= cfg.length;
    for (int i = 0; i < MaxPattern; i++) begin
      if ((CntW'(i) < cfg.length) && cfg.care[i]) begin
        if (stage.window[len_m1 - IdxW'(i)] != cfg.pattern[i]) begin
          hit = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage.pending && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.pending) begin
      match_address <= stage.addr - AddrW'(len_m1);
    end
  end

endmodule

[hw/rtl/masked_byte_pattern_scan_unit.sv]
// Masked byte pattern scan unit: takes one byte word per cycle when not stalled and reports
// the start address of every window of pattern_length bytes inside one region that equals
// the pattern on the care positions. An accepted byte first loads the window register, and
// the result register is loaded from it once the result register is empty or being read.
// Input is taken whenever the result register is empty or being read, so the unit sustains
// one word per cycle; configuration is always ready.
// Depends on mbps_pkg, mbps_cfg, mbps_window and mbps_match.
module masked_byte_pattern_scan_unit
  import mbps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ByteW-1:0]    data_byte,
  input  logic [AddrW-1:0]    byte_address,
  input  logic                region_first,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [AddrW-1:0]    match_address
);

  cfg_t   cfg;
  stage_t stage;
  logic   advance;
  logic   accept;

  assign in_ready = advance;
  assign accept   = in_valid && advance;

  mbps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbps_window u_window (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .advance      (advance),
    .data_byte    (data_byte),
    .byte_address (byte_address),
    .region_first (region_first),
    .stage        (stage)
  );

  mbps_match u_match (
    .clk           (clk),
    .rst           (rst),
    .stage         (stage),
    .cfg           (cfg),
    .out_ready     (out_ready),
    .advance       (advance),
    .out_valid     (out_valid),
    .match_address (match_address)
  );

endmodule

[hw/rtl/mbps_checker.sv]
// Port-level checks of the scan unit, bound to the top level.
// Depends on mbps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbps_checker
  import mbps_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [AddrW-1:0] match_address
);

  // A stalled result word holds its address.
  `AST_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(match_address))

  // No result survives reset.
  `AST_ALWAYS(a_rst_clear, rst |=> !out_valid)

  // A new result always follows an accepted byte word, which first passes the window register.
  `AST_CLK(a_out_cause, $rose(out_valid) |-> $past(in_valid && in_ready, 2))

  // With the result register empty the unit never stalls its input.
  `AST_CLK(a_in_free, !out_valid |-> in_ready)

endmodule

bind masked_byte_pattern_scan_unit mbps_checker u_checker (.*);

[tb/mbps_scan_checker.sv]
// Checker for the masked byte pattern scan unit. It watches the configuration, byte and match
// channels, predicts every match address and compares it. Depends on mbps_pkg only.
module mbps_scan_checker
  import mbps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [ByteW-1:0]    data_byte,
  input  logic [AddrW-1:0]    byte_address,
  input  logic                region_first,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [AddrW-1:0]    match_address,
  output int unsigned         mismatches,
  output int unsigned         hits_owed,
  output int unsigned         bytes_seen,
  output int unsigned         hits_seen
);

  logic [2*CfgDataW-1:0] pattern_q;
  logic [MaxPattern-1:0] care_q;
  logic [CntW-1:0]       length_q;
  win_t                  recent;
  logic [CntW-1:0]       fill;
  logic [AddrW-1:0]      owed_addr[$];

  initial begin
    mismatches = 0;
    hits_owed  = 0;
    bytes_seen = 0;
    hits_seen  = 0;
  end

  // Compares the newest span bytes with the pattern; the oldest byte lines up with byte 0.
  function automatic bit window_hits(input win_t w, input logic [CntW-1:0] filled,
                                     output int span);
    span = (length_q == 0) ? 1 : (length_q > MaxPattern) ? MaxPattern : int'(length_q);
    if (filled < span) return 1'b0;
    for (int i = 0; i < span; i++)
      if (care_q[i] && w[span-1-i] != pattern_q[ByteW*i +: ByteW]) return 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    win_t             w_next;
    logic [CntW-1:0]  fill_next;
    logic [AddrW-1:0] start_addr;
    logic [AddrW-1:0] want;
    int               span;
    if (rst) begin
      pattern_q <= '0;
      care_q    <= '1;
      length_q  <= CntW'(1);
      recent    <= '0;
      fill      <= '0;
      owed_addr.delete();
      hits_owed = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          RegPatLow:   pattern_q[CfgDataW-1:0] <= cfg_data;
          RegPatHigh:  pattern_q[2*CfgDataW-1:CfgDataW] <= cfg_data;
          RegCareMask: care_q <= cfg_data[MaxPattern-1:0];
          RegPatLen:   length_q <= cfg_data[CntW-1:0];
          default: ;
        endcase
      end
      // The match word is checked before this edge's byte is predicted, since a byte's
      // result can never leave on the edge that takes it.
      if (out_valid && out_ready) begin
        hits_seen++;
        if (owed_addr.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: match word at %h with none expected", $realtime, match_address);
          mismatches++;
        end else begin
          want = owed_addr.pop_front();
          if (want != match_address) begin
            if (mismatches < 10)
              $display("%0t: match_address expected %h, got %h", $realtime, want,
                       match_address);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        bytes_seen++;
        w_next    = {recent[MaxPattern-2:0], data_byte};
        fill_next = region_first ? CntW'(1) : (fill < MaxPattern) ? fill + 1'b1 : fill;
        recent   <= w_next;
        fill     <= fill_next;
        if (window_hits(w_next, fill_next, span)) begin
          start_addr = byte_address - AddrW'(span - 1);
          owed_addr  = {owed_addr, start_addr};
        end
      end
      hits_owed = owed_addr.size();
    end
  end

endmodule

[tb/masked_byte_pattern_scan_unit_test.sv]
// Top of the scan unit testbench: clock, reset, byte and configuration stimulus and the verdict.
// Depends on mbps_pkg, the scan unit and the mbps_scan_checker module.
module masked_byte_pattern_scan_unit_test;
  import mbps_pkg::*;

  localparam logic [AddrW-1:0] AddrMax = {AddrW{1'b1}};
  localparam int               ByteTarget = 1950;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = RegPatLow;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ByteW-1:0]    data_byte = '0;
  logic [AddrW-1:0]    byte_address = '0;
  logic                region_first = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  logic [AddrW-1:0]    match_address;
  int unsigned         mismatches, hits_owed, bytes_seen, hits_seen;

  // Settings as last written, used only to plant pattern runs in the byte stream.
  logic [2*CfgDataW-1:0] pattern = '0;
  logic [MaxPattern-1:0] care_bits = '1;
  logic [CntW-1:0]       len_raw = CntW'(1);
  logic [AddrW-1:0]      addr_next = '0;
  bit                    stall_on = 1'b1;
  int                    sent = 0;
  int                    settings_used = 1;

  masked_byte_pattern_scan_unit DUT (.*);
  mbps_scan_checker checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Match words are read with random stall bursts while stalling is enabled.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Entered and left at a falling edge.
  task automatic push_byte(input logic [ByteW-1:0] b, input logic [AddrW-1:0] a,
                           input bit f);
    if (stall_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    byte_address <= a;
    region_first <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic cfg_put(input cfg_reg_t idx, input logic [CfgDataW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_scan(input logic [CfgDataW-1:0] lo, input logic [CfgDataW-1:0] hi,
                              input logic [CfgDataW-1:0] care, input logic [CfgDataW-1:0] len);
    cfg_put(RegPatLow, lo);
    cfg_put(RegPatHigh, hi);
    cfg_put(RegCareMask, care);
    cfg_put(RegPatLen, len);
    cfg_valid <= 1'b0;
    pattern   = {hi, lo};
    care_bits = care[MaxPattern-1:0];
    len_raw   = len[CntW-1:0];
    settings_used++;
    @(negedge clk);
  endtask

  // Holds the byte channel idle until every predicted match has left, then keeps waiting so
  // that a byte that gives no match also leaves the pipeline before anything is reconfigured.
  task automatic drain();
    in_valid <= 1'b0;
    while (hits_owed != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic scan_phase(input int count);
    int               span, region_left, plant_at, pick;
    logic [ByteW-1:0] b;
    logic [AddrW-1:0] a;
    bit               f;
    span = (len_raw == 0) ? 1 : (len_raw > MaxPattern) ? MaxPattern : int'(len_raw);
    region_left = 0;
    plant_at = -1;
    repeat (count) begin
      f = (region_left == 0);
      if (f) begin
        region_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(span, 3*span + 12);
        addr_next = ($urandom_range(0, 5) == 0) ? AddrMax - AddrW'($urandom_range(0, 20))
                                                : AddrW'({$urandom(), $urandom()});
      end
      region_left--;
      if (plant_at < 0 && $urandom_range(0, 3) == 0) plant_at = 0;
      if (plant_at >= 0) begin
        b = care_bits[plant_at] ? pattern[ByteW*plant_at +: ByteW] : ByteW'($urandom());
        // A single flipped bit now and then gives a near miss.
        if ($urandom_range(0, 9) == 0) b = b ^ (8'h01 << $urandom_range(0, 7));
        plant_at = (plant_at + 1 == span) ? -1 : plant_at + 1;
      end else if ($urandom_range(0, 1) == 0) begin
        b = ByteW'($urandom());
      end else begin
        pick = $urandom_range(0, MaxPattern - 1);
        b = pattern[ByteW*pick +: ByteW];
      end
      a = ($urandom_range(0, 19) == 0) ? AddrW'({$urandom(), $urandom()}) : addr_next;
      addr_next = addr_next + 1'b1;
      push_byte(b, a, f);
    end
  endtask

  initial begin
    logic [CfgDataW-1:0] lo, hi, care, len;
    int                  kind;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Settings straight out of reset: one byte, pattern zero, every position cared for.
    push_byte(8'h00, '0, 1'b1);
    push_byte(8'hFF, AddrMax, 1'b0);
    push_byte(8'h00, AddrMax, 1'b0);
    drain();

    // A length of zero behaves as one.
    program_scan('1, '0, 64'hFFFF, 64'd0);
    push_byte(8'hFF, 47'h123, 1'b1);
    push_byte(8'hFE, 47'h124, 1'b0);
    drain();

    // Oversized length clamps to the full window; with no care bits every full window
    // matches, and the start address wraps below zero.
    program_scan(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'h0, 64'd31);
    push_byte(8'h11, AddrMax - 9, 1'b1);
    push_byte(8'h22, AddrMax - 8, 1'b0);
    for (int i = 0; i < 17; i++)
      push_byte(ByteW'($urandom()), AddrMax - 9 + AddrW'(i), i == 0);
    drain();

    while (sent < ByteTarget) begin
      if (sent > ByteTarget - 250) stall_on = 1'b0;
      lo = {$urandom(), $urandom()};
      hi = {$urandom(), $urandom()};
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        lo = '0;
        hi = '0;
      end else if (kind == 1) begin
        lo = '1;
        hi = '1;
      end
      care = {$urandom(), $urandom()};
      kind = $urandom_range(0, 7);
      if (kind == 0) care[MaxPattern-1:0] = '1;
      else if (kind == 1) care[MaxPattern-1:0] = '0;
      len = {$urandom(), $urandom()};
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: len[CntW-1:0] = CntW'($urandom_range(1, 4));
        4, 5:       len[CntW-1:0] = CntW'($urandom_range(5, 15));
        6:          len[CntW-1:0] = CntW'(16);
        7:          len[CntW-1:0] = '0;
        8:          len[CntW-1:0] = CntW'($urandom_range(17, 31));
        default:    len[CntW-1:0] = CntW'(1);
      endcase
      program_scan(lo, hi, care, len);
      scan_phase($urandom_range(80, 200));
      drain();
    end

    $display("Scanned %0d bytes under %0d pattern settings, lengths 0 to 31 and masks",
             bytes_seen, settings_used);
    $display("from all wildcards to all cared; %0d match words were checked.", hits_seen);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
